[rtl/core/assert_macros.svh]
// Assertion macros used by the RTL of the collision unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds in the same cycle as its trigger.
`define CAA_ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// Condition holds in the cycle after its trigger.
`define CAA_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

[rtl/core/caa_pkg.sv]
// Types, constants and helper functions of the circle versus rectangle collision unit.
package caa_pkg;

   localparam int unsigned NORM_BITS = 16;
   localparam int unsigned RES_W     = 100;
   localparam logic [NORM_BITS-1:0] NORM_MAX = 16'd32767;

   typedef struct packed {
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [31:0] rect_left;
      logic signed [31:0] rect_bottom;
      logic [30:0]        rect_width;
      logic [30:0]        rect_height;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic               center_inside;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
   } rsp_type;

   // Offset of one centre coordinate from the rectangle, as sign and magnitude.
   typedef struct packed {
      logic        neg;
      logic [31:0] mag;
   } axis_type;

   // One normal component under refinement: residual, running product and result bits.
   typedef struct packed {
      logic signed [RES_W-1:0] resid;
      logic signed [RES_W-1:0] prod;
      logic [NORM_BITS-1:0]    q;
   } lane_type;

   typedef struct packed {
      logic        valid;
      logic        hit;
      logic        enclosed;
      logic        neg_x;
      logic        neg_y;
      logic [63:0] len2;
      lane_type    lane_x;
      lane_type    lane_y;
   } cell_type;

   function automatic axis_type axis_offset(input logic signed [31:0] c,
                                            input logic signed [31:0] lo,
                                            input logic [30:0] ext);
      logic signed [33:0] c34;
      logic signed [33:0] lo34;
      logic signed [33:0] hi34;
      logic signed [33:0] d;
      logic signed [33:0] nd;
      axis_type r;
      c34  = {{2{c[31]}}, c};
      lo34 = {{2{lo[31]}}, lo};
      hi34 = lo34 + $signed({3'b000, ext});
      if (c34 < lo34) begin
         d = c34 - lo34;
      end else if (c34 > hi34) begin
         d = c34 - hi34;
      end else begin
         d = '0;
      end
      nd = -d;
      if (d > 34'sd2147483647) begin
         r.neg = 1'b0;
         r.mag = 32'h7FFF_FFFF;
      end else if (d < -34'sd2147483648) begin
         r.neg = 1'b1;
         r.mag = 32'h8000_0000;
      end else if (d < 34'sd0) begin
         r.neg = 1'b1;
         r.mag = nd[31:0];
      end else begin
         r.neg = 1'b0;
         r.mag = d[31:0];
      end
      return r;
   endfunction

   // Try to set result bit k: accept it when (2q'-1)^2 * len2 stays within 2^32 * a^2.
   function automatic lane_type lane_step(input lane_type l, input logic [63:0] len2,
                                          input int unsigned k);
      logic signed [RES_W-1:0] lw;
      logic signed [RES_W-1:0] term;
      logic signed [RES_W-1:0] cand;
      lane_type r;
      lw   = $signed({{(RES_W-64){1'b0}}, len2});
      term = (l.prod <<< (k + 2)) + (lw <<< (2 * k + 2));
      cand = l.resid - term;
      r    = l;
      if (!cand[RES_W-1]) begin
         r.resid = cand;
         r.prod  = l.prod + (lw <<< (k + 1));
         r.q     = l.q | (NORM_BITS'(1) << k);
      end
      return r;
   endfunction

endpackage

[rtl/core/caa_norm_cell.sv]
// One cell of the normal refinement row: decides one result bit of both components.
module caa_norm_cell #(
   parameter int unsigned BIT = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  caa_pkg::cell_type cell_in,
   output caa_pkg::cell_type cell_out
);

   caa_pkg::cell_type data_in;
   caa_pkg::cell_type data_ff;
   logic              valid_ff;

   always_comb begin
      data_in        = cell_in;
      data_in.lane_x = caa_pkg::lane_step(cell_in.lane_x, cell_in.len2, BIT);
      data_in.lane_y = caa_pkg::lane_step(cell_in.lane_y, cell_in.len2, BIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= cell_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

   always_comb begin
      cell_out       = data_ff;
      cell_out.valid = valid_ff;
   end

endmodule

[rtl/core/caa_norm_chain.sv]
// Row of refinement cells, most significant result bit first.
module caa_norm_chain (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  caa_pkg::cell_type chain_in,
   output caa_pkg::cell_type chain_out
);

   caa_pkg::cell_type link [caa_pkg::NORM_BITS+1];

   assign link[0] = chain_in;

   for (genvar i = 0; i < caa_pkg::NORM_BITS; i++) begin : g_cell
      caa_norm_cell #(
         .BIT(caa_pkg::NORM_BITS - 1 - i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .enable  (enable),
         .cell_in (link[i]),
         .cell_out(link[i+1])
      );
   end

   assign chain_out = link[caa_pkg::NORM_BITS];

endmodule

[rtl/core/circle_aabb_collision_normal_unit.sv]
// Top level of the circle versus axis-aligned rectangle collision unit.
// Throughput: one transaction per cycle unless a held-back response stalls the pipeline;
// four front stages feed a row of sixteen cells.
// The row decides one bit of the Q1.15 normal per cell, so its length sets the latency.
// Reset (synchronous, active high) empties the pipeline and clears the radius to zero.
`include "assert_macros.svh"

module circle_aabb_collision_normal_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  caa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output caa_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [30:0]      csr_data
);

   // The radius register; the user must write it only while the unit is idle, which the block itself does not enforce.
   logic [30:0] radius_ff;
   logic [30:0] radius_in;

   assign csr_ready = 1'b1;
   assign radius_in = (csr_valid && csr_ready) ? csr_data : radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= '0;
      end else begin
         radius_ff <= radius_in;
      end
   end

   // The whole pipeline moves together, and freezes only while a finished
   // response is held back by the downstream side.
   logic enable;
   assign enable    = !(rsp_valid && rsp_stall);
   assign req_stall = !enable;

   // Stage A: clamp the centre into the rectangle and take the saturated offset.
   caa_pkg::axis_type ax_in, ay_in, ax_ff, ay_ff;
   logic              va_ff;

   assign ax_in = caa_pkg::axis_offset(req_data.center_x, req_data.rect_left,
                                       req_data.rect_width);
   assign ay_in = caa_pkg::axis_offset(req_data.center_y, req_data.rect_bottom,
                                       req_data.rect_height);

   // Stage B: square the offsets and the radius, each with its own multiplier.
   logic [63:0] ax2_in, ay2_in, ax2_ff, ay2_ff;
   logic [61:0] r2_in, r2_ff;
   logic        negx_b_ff, negy_b_ff, vb_ff;

   assign ax2_in = 64'(ax_ff.mag) * 64'(ax_ff.mag);
   assign ay2_in = 64'(ay_ff.mag) * 64'(ay_ff.mag);
   assign r2_in  = 62'(radius_ff) * 62'(radius_ff);

   // Stage C: squared length and the strict radius comparison. The centre lies
   // in the closed rectangle exactly when the squared length is zero.
   logic [63:0] len2_in, len2_ff, ax2_c_ff, ay2_c_ff;
   logic        hit_in, hit_ff, negx_c_ff, negy_c_ff, vc_ff;

   assign len2_in = ax2_ff + ay2_ff;
   assign hit_in  = len2_in < {2'b00, r2_ff};

   // Stage D: starting residuals 2^32 * a^2 - len2, with the running product
   // t * len2 seeded for t = -1.
   caa_pkg::cell_type head_in, head_ff;
   logic              vd_ff;

   always_comb begin
      head_in              = '0;
      head_in.valid        = vc_ff;
      head_in.hit          = hit_ff;
      head_in.enclosed     = (len2_ff == 64'd0);
      head_in.neg_x        = negx_c_ff;
      head_in.neg_y        = negy_c_ff;
      head_in.len2         = len2_ff;
      head_in.lane_x.resid = $signed({4'b0000, ax2_c_ff, 32'd0})
                             - $signed({36'd0, len2_ff});
      head_in.lane_y.resid = $signed({4'b0000, ay2_c_ff, 32'd0})
                             - $signed({36'd0, len2_ff});
      head_in.lane_x.prod  = -$signed({36'd0, len2_ff});
      head_in.lane_y.prod  = -$signed({36'd0, len2_ff});
      head_in.lane_x.q     = '0;
      head_in.lane_y.q     = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else if (enable) begin
         va_ff <= req_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         ax_ff     <= ax_in;
         ay_ff     <= ay_in;
         ax2_ff    <= ax2_in;
         ay2_ff    <= ay2_in;
         r2_ff     <= r2_in;
         negx_b_ff <= ax_ff.neg;
         negy_b_ff <= ay_ff.neg;
         len2_ff   <= len2_in;
         hit_ff    <= hit_in;
         ax2_c_ff  <= ax2_ff;
         ay2_c_ff  <= ay2_ff;
         negx_c_ff <= negx_b_ff;
         negy_c_ff <= negy_b_ff;
         head_ff   <= head_in;
      end
   end

   // The refinement row: each cell fixes one bit of both normal components.
   caa_pkg::cell_type chain_in, tail;

   always_comb begin
      chain_in       = head_ff;
      chain_in.valid = vd_ff;
   end

   caa_norm_chain u_chain (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .chain_in (chain_in),
      .chain_out(tail)
   );

   // Output shaping: a magnitude of exactly one is limited to the largest
   // Q1.15 value, the sign follows the offset, and no hit or an enclosed
   // centre gives a zero normal.
   logic [15:0] mag_x, mag_y;
   logic        show_normal;

   assign mag_x       = tail.lane_x.q[15] ? caa_pkg::NORM_MAX : tail.lane_x.q;
   assign mag_y       = tail.lane_y.q[15] ? caa_pkg::NORM_MAX : tail.lane_y.q;
   assign show_normal = tail.hit && !tail.enclosed;

   assign rsp_valid              = tail.valid;
   assign rsp_data.hit           = tail.hit;
   assign rsp_data.center_inside = tail.enclosed;
   assign rsp_data.normal_x      = !show_normal ? 16'sd0
                                   : (tail.neg_x ? -$signed(mag_x) : $signed(mag_x));
   assign rsp_data.normal_y      = !show_normal ? 16'sd0
                                   : (tail.neg_y ? -$signed(mag_y) : $signed(mag_y));

   // A response without a hit carries a zero normal.
   `CAA_ASSERT_SAME(a_nohit_zero, clock, reset, rsp_valid && !rsp_data.hit,
                    rsp_data.normal_x == 16'sd0 && rsp_data.normal_y == 16'sd0)

   // An enclosed centre carries a zero normal.
   `CAA_ASSERT_SAME(a_enclosed_zero, clock, reset, rsp_valid && rsp_data.center_inside,
                    rsp_data.normal_x == 16'sd0 && rsp_data.normal_y == 16'sd0)

   // The limiting keeps both components inside the symmetric Q1.15 range.
   `CAA_ASSERT_SAME(a_norm_range, clock, reset, rsp_valid,
                    rsp_data.normal_x != -16'sd32768 && rsp_data.normal_y != -16'sd32768)

endmodule

[bench/tb.sv]
// Self-checking testbench of the circle versus rectangle collision unit.
module tb;

   // Clock, reset and the ports of the block.  Every input starts at a known value.
   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   caa_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   caa_pkg::rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [30:0] csr_data = '0;

   // Extra idle margin once every owed response has come back.
   localparam int DRAIN_CYCLES = 30;
   localparam int HOLD_CYCLES  = 200;

   // The radius that the predictor believes the block holds.
   logic [30:0] radius_shadow = '0;

   // Responses still owed by the block, oldest first.
   caa_pkg::rsp_type owed_rsp[$];

   // Idling rates of the present phase, in percent.
   int send_gap_pct = 0;
   int rsp_stall_pct = 0;

   // The long hold-off of the receiver is counted in its own process below.
   int hold_request = 0;
   int hold_seen = 0;
   int hold_left = 0;

   int error_count = 0;
   int sent_count = 0;
   int checked_count = 0;
   int hit_count = 0;
   int inside_count = 0;

   circle_aabb_collision_normal_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // Offset of one centre coordinate from the interval [lo, lo + ext], computed
   // without wrap and then saturated to the signed 32-bit range.
   function automatic longint clamped_offset(input logic signed [31:0] c,
                                             input logic signed [31:0] lo,
                                             input logic [30:0] ext);
      longint cc;
      longint ll;
      longint hh;
      longint d;
      cc = longint'(c);
      ll = longint'(lo);
      hh = ll + longint'(ext);
      if (cc < ll) begin
         d = cc - ll;
      end else if (cc > hh) begin
         d = cc - hh;
      end else begin
         d = 0;
      end
      if (d > 64'sd2147483647) begin
         d = 64'sd2147483647;
      end else if (d < -64'sd2147483648) begin
         d = -64'sd2147483648;
      end
      return d;
   endfunction

   // Rounded Q1.15 magnitude a / sqrt(len2), found by bisection on an exact
   // comparison of (2q - 1)^2 * len2 against 2^32 * a^2.
   function automatic logic [15:0] unit_magnitude(input logic [63:0] a,
                                                  input logic [63:0] len2);
      logic [63:0]  lo;
      logic [63:0]  hi;
      logic [63:0]  mid;
      logic [127:0] lhs;
      logic [127:0] rhs;
      lo = 64'd0;
      hi = 64'd32768;
      if (a == 0 || len2 == 0) begin
         return 16'd0;
      end
      rhs = 128'(a * a) << 32;
      while (lo < hi) begin
         mid = (lo + hi + 64'd1) >> 1;
         lhs = 128'((64'd2 * mid - 64'd1) * (64'd2 * mid - 64'd1)) * 128'(len2);
         if (lhs <= rhs) begin
            lo = mid;
         end else begin
            hi = mid - 64'd1;
         end
      end
      if (lo > 64'(caa_pkg::NORM_MAX)) begin
         lo = 64'(caa_pkg::NORM_MAX);
      end
      return lo[15:0];
   endfunction

   // The collision response the block should give for one request.
   function automatic caa_pkg::rsp_type predict_contact(input caa_pkg::req_type q);
      longint      dx;
      longint      dy;
      logic [63:0] ax;
      logic [63:0] ay;
      logic [63:0] len2;
      logic [63:0] r2;
      logic [15:0] mx;
      logic [15:0] my;
      caa_pkg::rsp_type r;
      dx = clamped_offset(q.center_x, q.rect_left, q.rect_width);
      dy = clamped_offset(q.center_y, q.rect_bottom, q.rect_height);
      ax = (dx < 0) ? 64'(-dx) : 64'(dx);
      ay = (dy < 0) ? 64'(-dy) : 64'(dy);
      len2 = ax * ax + ay * ay;
      r2 = 64'(radius_shadow) * 64'(radius_shadow);
      r = '0;
      r.hit = (len2 < r2);
      r.center_inside = (dx == 0 && dy == 0);
      if (r.hit && !r.center_inside) begin
         mx = unit_magnitude(ax, len2);
         my = unit_magnitude(ay, len2);
         r.normal_x = (dx < 0) ? -mx : mx;
         r.normal_y = (dy < 0) ? -my : my;
      end
      return r;
   endfunction

   // The receiver stalls at random, and for a long stretch on request.
   always @(posedge clock) begin
      if (hold_request != hold_seen) begin
         hold_seen = hold_request;
         hold_left = HOLD_CYCLES;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
      end
      rsp_stall <= (hold_left > 0) || ($urandom_range(99) < rsp_stall_pct);
   end

   // Every accepted response transaction is compared with the oldest one owed.
   always @(posedge clock) begin
      caa_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (owed_rsp.size() == 0) begin
            $error("response with none owed: %p", rsp_data);
            error_count++;
         end else begin
            want = owed_rsp.pop_front();
            checked_count++;
            if (want.hit) hit_count++;
            if (want.center_inside) inside_count++;
            if (rsp_data.hit !== want.hit) begin
               $error("hit: expected %0d, got %0d", want.hit, rsp_data.hit);
               error_count++;
            end
            if (rsp_data.center_inside !== want.center_inside) begin
               $error("center_inside: expected %0d, got %0d",
                      want.center_inside, rsp_data.center_inside);
               error_count++;
            end
            if (rsp_data.normal_x !== want.normal_x) begin
               $error("normal_x: expected %0d, got %0d", want.normal_x, rsp_data.normal_x);
               error_count++;
            end
            if (rsp_data.normal_y !== want.normal_y) begin
               $error("normal_y: expected %0d, got %0d", want.normal_y, rsp_data.normal_y);
               error_count++;
            end
         end
      end
   end

   // Offer one request transaction and hold it until the block takes it.
   task automatic send_request(input caa_pkg::req_type q);
      req_valid <= 1'b1;
      req_data  <= q;
      do begin
         @(posedge clock);
      end while (req_stall);
      owed_rsp.push_back(predict_contact(q));
      sent_count++;
      if ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   // Lower the request valid and wait until every owed response has come back.
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (owed_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write the radius register; only called while the block is idle.
   task automatic write_radius(input logic [30:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      radius_shadow = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic caa_pkg::req_type make_request(input logic signed [31:0] cx,
                                                     input logic signed [31:0] cy,
                                                     input logic signed [31:0] left,
                                                     input logic signed [31:0] bottom,
                                                     input logic [30:0] w,
                                                     input logic [30:0] h);
      caa_pkg::req_type q;
      q.center_x = cx;
      q.center_y = cy;
      q.rect_left = left;
      q.rect_bottom = bottom;
      q.rect_width = w;
      q.rect_height = h;
      return q;
   endfunction

   // A random request: mostly a circle near a modest rectangle, so that hits
   // and all the normal directions occur, with some fully random noise.
   function automatic caa_pkg::req_type random_request();
      caa_pkg::req_type q;
      int      span;
      if ($urandom_range(3) == 0) begin
         q.center_x = $urandom;
         q.center_y = $urandom;
         q.rect_left = $urandom;
         q.rect_bottom = $urandom;
         q.rect_width = 31'($urandom);
         q.rect_height = 31'($urandom);
      end else begin
         span = 1 << $urandom_range(22, 12);
         q.rect_left = $urandom_range(2 * span) - span;
         q.rect_bottom = $urandom_range(2 * span) - span;
         q.rect_width = 31'($urandom_range(span));
         q.rect_height = 31'($urandom_range(span));
         q.center_x = q.rect_left + $urandom_range(4 * span) - 2 * span;
         q.center_y = q.rect_bottom + $urandom_range(4 * span) - 2 * span;
      end
      return q;
   endfunction

   // Extremes of the fields and the special cases, first with the reset
   // radius of zero, then with the largest radius, last near a radius of 65536.
   task automatic test_directed();
      caa_pkg::req_type list[$];
      list.push_back(make_request(32'sd0, 32'sd0, 32'sd0, 32'sd0, 31'd0, 31'd0));
      list.push_back(make_request(32'sd65536, 32'sd0, 32'sd0, 32'sd0, 31'd0, 31'd0));
      for (int pass = 0; pass < 2; pass++) begin
         foreach (list[i]) send_request(list[i]);
         drain_responses();
         if (pass == 0) begin
            write_radius(31'h7FFF_FFFF);
            list.delete();
            // Centre inside, and exactly on a corner.
            list.push_back(make_request(32'sd5, 32'sd5, 32'sd0, 32'sd0, 31'd10, 31'd10));
            list.push_back(make_request(32'sd10, 32'sd10, 32'sd0, 32'sd0, 31'd10, 31'd10));
            // Axis-aligned normals in all four directions.
            list.push_back(make_request(32'sd100, 32'sd5, 32'sd0, 32'sd0, 31'd10, 31'd10));
            list.push_back(make_request(-32'sd100, 32'sd5, 32'sd0, 32'sd0, 31'd10, 31'd10));
            list.push_back(make_request(32'sd5, 32'sd100, 32'sd0, 32'sd0, 31'd10, 31'd10));
            list.push_back(make_request(32'sd5, -32'sd100, 32'sd0, 32'sd0, 31'd10, 31'd10));
            // Diagonals.
            list.push_back(make_request(32'sd20, 32'sd20, 32'sd0, 32'sd0, 31'd10, 31'd10));
            list.push_back(make_request(-32'sd7, -32'sd3, 32'sd0, 32'sd0, 31'd0, 31'd0));
            // A very wide rectangle whose right and top edges exceed 32 bits.
            list.push_back(make_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                        32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF));
            list.push_back(make_request(32'sh8000_0000, 32'sh8000_0000, 32'h7FFF_FFFF,
                                        32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF));
            // Far centres whose offsets saturate, and a centre just off a corner.
            list.push_back(make_request(32'h7FFF_FFFF, 32'sd0, 32'sh8000_0000, 32'sd0,
                                        31'd0, 31'd0));
            list.push_back(make_request(32'sh8000_0000, 32'sh8000_0000, 32'h7FFF_FFFF,
                                        32'h7FFF_FFFF, 31'd0, 31'd0));
            list.push_back(make_request(32'h7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
                                        32'h7FFF_FFFF, 31'd0, 31'd0));
            list.push_back(make_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'sd0, 32'sd0,
                                        31'h7FFF_FFFF, 31'd0));
         end
      end
      // Just inside and just outside a radius of 65536.
      write_radius(31'h0001_0000);
      send_request(make_request(32'sh0000_FFFF, 32'sd0, 32'sd0, 32'sd0, 31'd0, 31'd0));
      send_request(make_request(32'sh0001_0000, 32'sd0, 32'sd0, 32'sd0, 31'd0, 31'd0));
      send_request(make_request(32'sd0, -32'sh0000_B505, 32'sd0, 32'sd0, 31'd0, 31'd0));
      drain_responses();
   endtask

   // Random requests under one idling setting and one radius.
   task automatic test_random(input int count, input int gap_pct, input int stall_pct,
                              input logic [30:0] radius_value);
      write_radius(radius_value);
      send_gap_pct = gap_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) send_request(random_request());
      drain_responses();
   endtask

   // The receiver holds off long enough for the pipeline to fill and stall
   // the sender, which keeps offering back to back.
   task automatic test_backpressure();
      write_radius(31'h0040_0000);
      send_gap_pct = 0;
      rsp_stall_pct = 0;
      hold_request++;
      repeat (60) send_request(random_request());
      drain_responses();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(100, 0, 0, 31'h0008_0000);
      test_random(90, 62, 0, 31'h7FFF_FFFF);
      test_random(90, 0, 62, 31'h0000_0001);
      test_random(90, 13, 13, 31'h0030_0000);
      test_backpressure();
      test_random(30, 13, 13, 31'd0);
      $display("Sent %0d requests and checked %0d responses (%0d hits, %0d centres inside).",
               sent_count, checked_count, hit_count, inside_count);
      $display("Covered extreme fields, several radius settings, idling and a long stall.");
      if (error_count == 0 && owed_rsp.size() == 0) begin
         $display("circle_aabb_collision_normal_unit verification clean");
      end else begin
         $display("circle_aabb_collision_normal_unit verification failed");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("circle_aabb_collision_normal_unit verification failed");
      $finish;
   end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/caa_pkg.sv
rtl/core/caa_norm_cell.sv
rtl/core/caa_norm_chain.sv
rtl/core/circle_aabb_collision_normal_unit.sv
bench/tb.sv
